[sv/cnt_pkg.sv]
// ----------------------------------------------------------------------------
// cnt_pkg
// Shared widths and types for the Carmichael number test core.
// ----------------------------------------------------------------------------
package cnt_pkg;
    localparam int VALUE_BITS = 16;
    localparam int IN_BITS    = 16;
    localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [CNT_BITS-1:0]   t_count;

    // Request to the bit-serial modular multiplier.
    typedef struct packed {
        logic   start;
        t_value a;
        t_value b;
    } t_mul_req;
endpackage

[sv/cnt_mulmod.sv]
// ----------------------------------------------------------------------------
// cnt_mulmod
// Bit-serial modular multiplier: a*b mod m, one bit of b per cycle.
// ----------------------------------------------------------------------------
module cnt_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cnt_pkg::t_mul_req i_req,
    input  cnt_pkg::t_value   i_mod,
    output logic              o_done,
    output cnt_pkg::t_value   o_prod
);
    import cnt_pkg::*;

    logic          r_busy;
    t_count        r_cnt;
    t_value        r_a;
    t_value        r_b;
    t_value        r_acc;
    logic [VALUE_BITS:0] w_dbl;
    logic [VALUE_BITS:0] w_dbl_red;
    logic [VALUE_BITS:0] w_add;
    t_value        w_next;

    // Horner step, MSB first: acc = 2*acc (+a), each reduced once (acc, a < m).
    always_comb begin
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= {1'b0, i_mod}) ? w_dbl - {1'b0, i_mod} : w_dbl;
        w_add     = w_dbl_red + {1'b0, r_a};
        if (r_b[VALUE_BITS-1]) begin
            w_next = (w_add >= {1'b0, i_mod}) ? VALUE_BITS'(w_add - {1'b0, i_mod})
                                               : VALUE_BITS'(w_add);
        end else begin
            w_next = VALUE_BITS'(w_dbl_red);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_cnt  <= CNT_BITS'(VALUE_BITS);
            end else if (r_busy) begin
                r_acc <= w_next;
                r_b   <= {r_b[VALUE_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod = r_acc;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("busy with zero count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("done without work");
endmodule

[sv/carmichael_number_test_core.sv]
// ----------------------------------------------------------------------------
// carmichael_number_test_core
// Carmichael test: sweep bases, binary gcd, Fermat check by square-and-multiply.
// ----------------------------------------------------------------------------
// Candidates below 3 go from the base check straight to the result. Otherwise each
// base costs a binary gcd and, if coprime, up to 2*VALUE_BITS serial multiplies
// (squares and multiplies) on the bit-serial multiplier.
// One item at a time: a new candidate is taken only once the last result is gone.
// Reset: synchronous active-low; returns to idle, no result pending.
module carmichael_number_test_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [cnt_pkg::IN_BITS-1:0] i_candidate,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_is_carmichael
);
    import cnt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_BASE, S_GCD, S_EXP, S_SQ_WAIT, S_MUL_WAIT, S_CHECK, S_DONE
    } t_state;

    t_state   r_state;
    t_value   r_n;            // candidate
    t_value   r_base;         // base_counter
    t_value   r_gl, r_gr;     // gcd operands
    t_count   r_shift;        // common power of two in gcd
    t_value   r_acc;          // power_accumulator
    t_value   r_sq;           // running square
    t_value   r_exp;          // exponent_shift
    logic     r_found;        // found_common_factor
    logic     r_failed;       // fermat_failed
    t_mul_req r_req;
    logic     n_start;
    logic     w_done;
    t_value   w_prod;

    cnt_mulmod u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_req),
        .i_mod  (r_n),
        .o_done (w_done),
        .o_prod (w_prod)
    );

    // Stall input while an item is in flight or a result waits.
    assign o_stall = (r_state != S_IDLE);

    // Pulse a multiplier start on each multiply or square issued.
    always_comb begin
        n_start = ((r_state == S_EXP) && (r_exp != '0)) ||
                  ((r_state == S_MUL_WAIT) && w_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            o_valid         <= 1'b0;
            o_is_carmichael <= 1'b0;
            r_req.start     <= 1'b0;
            r_found         <= 1'b0;
            r_failed        <= 1'b0;
        end else begin
            r_req.start <= n_start;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_n      <= t_value'(i_candidate);
                        r_found  <= 1'b0;
                        r_failed <= 1'b0;
                        r_base   <= VALUE_BITS'(2);
                        r_state  <= S_BASE;
                    end
                end
                S_BASE: begin
                    // Base past n-1 (or n < 3) ends the sweep.
                    if (r_base >= r_n) begin
                        r_state <= S_DONE;
                    end else begin
                        r_gl    <= r_n;
                        r_gr    <= r_base;
                        r_shift <= '0;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    // Binary gcd: one halving or subtract per cycle.
                    if (r_gl == r_gr) begin
                        if (r_shift != '0 || r_gl != VALUE_BITS'(1)) begin
                            r_found <= 1'b1;
                            r_base  <= r_base + 1'b1;
                            r_state <= S_BASE;
                        end else begin
                            r_acc   <= VALUE_BITS'(1);
                            r_sq    <= r_base;
                            r_exp   <= r_n;
                            r_state <= S_EXP;
                        end
                    end else if (!r_gl[0] && !r_gr[0]) begin
                        r_gl    <= r_gl >> 1;
                        r_gr    <= r_gr >> 1;
                        r_shift <= r_shift + 1'b1;
                    end else if (!r_gl[0]) begin
                        r_gl <= r_gl >> 1;
                    end else if (!r_gr[0]) begin
                        r_gr <= r_gr >> 1;
                    end else if (r_gl > r_gr) begin
                        r_gl <= r_gl - r_gr;
                    end else begin
                        r_gr <= r_gr - r_gl;
                    end
                end
                S_EXP: begin
                    // Scan exponent LSB first.
                    if (r_exp == '0) begin
                        r_state <= S_CHECK;
                    end else if (r_exp[0]) begin
                        r_req.a <= r_acc;
                        r_req.b <= r_sq;
                        r_state <= S_MUL_WAIT;
                    end else begin
                        r_req.a <= r_sq;
                        r_req.b <= r_sq;
                        r_state <= S_SQ_WAIT;
                    end
                end
                S_MUL_WAIT: begin
                    if (w_done) begin
                        r_acc   <= w_prod;
                        r_req.a <= r_sq;
                        r_req.b <= r_sq;
                        r_state <= S_SQ_WAIT;
                    end
                end
                S_SQ_WAIT: begin
                    if (w_done) begin
                        r_sq    <= w_prod;
                        r_exp   <= r_exp >> 1;
                        r_state <= S_EXP;
                    end
                end
                S_CHECK: begin
                    if (r_acc != r_base) begin
                        r_failed <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_base  <= r_base + 1'b1;
                        r_state <= S_BASE;
                    end
                end
                S_DONE: begin
                    // Hold the result until taken.
                    if (!o_valid) begin
                        o_valid         <= 1'b1;
                        o_is_carmichael <= r_found && !r_failed;
                    end else if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_DONE) else $error("result outside done");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_is_carmichael))
        else $error("stalled result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD) |-> r_gl != '0 && r_gr != '0) else $error("gcd hit zero");
endmodule
